>>> sv/rmq_pkg.sv
// Package for the read mapping quality block: item, result and read record types,
// register indexes and fixed widths. No dependencies.
package rmq_pkg;

	// Widths that cover the full range of MAX_BASES (1..128).
	localparam int unsigned TALLY_W = 8;
	localparam int unsigned SUM_W   = 13;

	// Configuration register indexes.
	localparam logic [1:0] CFG_QUALITY_CAP   = 2'd0;
	localparam logic [1:0] CFG_ALLOWED_MISM  = 2'd1;
	localparam logic [1:0] CFG_MISS_PENALTY  = 2'd2;

	// Item kinds.
	localparam logic REQ_HEADER = 1'b0;
	localparam logic REQ_BASE   = 1'b1;

	// Scoring constants.
	localparam logic [5:0] AVG_OFFSET   = 6'd13;
	localparam logic [6:0] MAX_MAP_QUAL = 7'd99;
	localparam logic [7:0] SUM_SAT      = 8'd255;
	localparam logic [3:0] COUNT_SAT    = 4'd15;

	typedef struct packed {
		logic       req_type;
		logic       has_match;
		logic       has_second_hit;
		logic [4:0] best_seed_mismatches;
		logic [4:0] second_seed_mismatches;
		logic [7:0] count_penalty;
		logic [7:0] base_qual;
		logic       best_mismatch;
		logic       second_mismatch;
		logic       last_base;
	} item_t;

	typedef struct packed {
		logic [6:0] map_score;
		logic       no_match;
		logic [7:0] mismatch_qual_sum;
		logic [3:0] mismatch_count;
	} result_t;

	// Everything the scoring side needs about one finished read.
	typedef struct packed {
		logic               has_match;
		logic               has_second;
		logic [4:0]         best_seed;
		logic [4:0]         second_seed;
		logic [7:0]         penalty;
		logic [SUM_W-1:0]   total_sum;
		logic [SUM_W-1:0]   best_sum;
		logic [SUM_W-1:0]   second_sum;
		logic [TALLY_W-1:0] mismatch_tally;
		logic [TALLY_W-1:0] base_tally;
	} rmq_rec_t;

	// Base penalty for a missing hit, chosen by the allowed mismatch count.
	function automatic logic [3:0] miss_base(input logic [1:0] allowed);
		logic [3:0] val;
		case (allowed)
			2'd0:    val = 4'd0;
			2'd1:    val = 4'd2;
			2'd2:    val = 4'd4;
			default: val = 4'd8;
		endcase
		return val;
	endfunction

endpackage

>>> sv/rmq_front.sv
// Front part of the read mapping quality block: latches read headers and accumulates
// base qualities one item per cycle while accept is high. Depends on rmq_pkg.
module rmq_front import rmq_pkg::*; #(
	parameter int unsigned MAX_BASES = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     accept,
	input  item_t    item,
	input  logic [5:0] quality_cap,
	output logic     rec_push,
	output rmq_rec_t rec
);

	logic               has_match_q;
	logic               has_second_q;
	logic [4:0]         best_seed_q;
	logic [4:0]         second_seed_q;
	logic [7:0]         penalty_q;
	logic [SUM_W-1:0]   total_q;
	logic [SUM_W-1:0]   best_q;
	logic [SUM_W-1:0]   second_q;
	logic [TALLY_W-1:0] mism_q;
	logic [TALLY_W-1:0] count_q;

	logic               take;
	logic [5:0]         qual;
	logic [SUM_W-1:0]   total_nx;
	logic [SUM_W-1:0]   best_nx;
	logic [SUM_W-1:0]   second_nx;
	logic [TALLY_W-1:0] mism_nx;
	logic [TALLY_W-1:0] count_nx;

	// Cap the quality and form the updated sums; bases past the limit are dropped.
	always_comb begin
		take      = (count_q < TALLY_W'(MAX_BASES));
		qual      = (item.base_qual[5:0] > quality_cap) ? quality_cap : item.base_qual[5:0];
		total_nx  = total_q;
		best_nx   = best_q;
		second_nx = second_q;
		mism_nx   = mism_q;
		count_nx  = count_q;
		if (take) begin
			total_nx = total_q + SUM_W'(qual);
			count_nx = count_q + 1'b1;
			if (item.best_mismatch) begin
				best_nx = best_q + SUM_W'(qual);
				mism_nx = mism_q + 1'b1;
			end
			if (item.second_mismatch) begin
				second_nx = second_q + SUM_W'(qual);
			end
		end
	end

	// A last base hands the finished read to the queue.
	assign rec_push = accept && (item.req_type == REQ_BASE) && item.last_base;

	always_comb begin
		rec.has_match      = has_match_q;
		rec.has_second     = has_second_q;
		rec.best_seed      = best_seed_q;
		rec.second_seed    = second_seed_q;
		rec.penalty        = penalty_q;
		rec.total_sum      = total_nx;
		rec.best_sum       = best_nx;
		rec.second_sum     = second_nx;
		rec.mismatch_tally = mism_nx;
		rec.base_tally     = count_nx;
	end

	// Header latches and accumulators.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_match_q   <= 1'b0;
			has_second_q  <= 1'b0;
			best_seed_q   <= '0;
			second_seed_q <= '0;
			penalty_q     <= '0;
			total_q       <= '0;
			best_q        <= '0;
			second_q      <= '0;
			mism_q        <= '0;
			count_q       <= '0;
		end else if (accept) begin
			if (item.req_type == REQ_HEADER || item.last_base) begin
				total_q  <= '0;
				best_q   <= '0;
				second_q <= '0;
				mism_q   <= '0;
				count_q  <= '0;
			end else begin
				total_q  <= total_nx;
				best_q   <= best_nx;
				second_q <= second_nx;
				mism_q   <= mism_nx;
				count_q  <= count_nx;
			end
			if (item.req_type == REQ_HEADER) begin
				has_match_q   <= item.has_match;
				has_second_q  <= item.has_second_hit;
				best_seed_q   <= item.best_seed_mismatches;
				second_seed_q <= item.second_seed_mismatches;
				penalty_q     <= item.count_penalty;
			end
		end
	end

endmodule

>>> sv/rmq_queue.sv
// Two-entry queue of finished read records between the front and back parts.
// Depends on rmq_pkg.
module rmq_queue import rmq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  rmq_rec_t wdata,
	input  logic     pop,
	output rmq_rec_t rdata,
	output logic     full,
	output logic     empty
);

	rmq_rec_t   mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign rdata = mem_q[rd_ptr_q];

	// Storage is written only on push and needs no reset.
	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop && !empty) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push && !full} - {1'b0, pop && !empty};
		end
	end

endmodule

>>> sv/rmq_back.sv
// Back part of the read mapping quality block: divides for the rounded average quality
// one quotient bit per cycle, scores the read and holds the result. Depends on rmq_pkg.
module rmq_back import rmq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  rmq_rec_t    rec,
	input  logic        rec_empty,
	output logic        rec_pop,
	input  logic [5:0]  quality_cap,
	input  logic [1:0]  allowed_mismatches,
	input  logic [39:0] missing_hit_penalties,
	input  logic        pop,
	output logic        empty,
	output result_t     result
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_DIV   = 2'd1;
	localparam logic [1:0] ST_SCORE = 2'd2;

	logic [1:0]   state_q;
	rmq_rec_t     rec_q;
	logic [14:0]  rem_q;
	logic [8:0]   div_q;
	logic [6:0]   quo_q;
	logic [2:0]   step_q;
	logic         out_valid_q;
	result_t      out_q;

	logic [14:0]  div_shift;
	logic         sub_ok;
	logic         out_free;
	logic [5:0]   avg_adj;
	logic signed [6:0]  budget;
	logic [2:0]   bud;
	logic [7:0]   pen;
	logic [9:0]   alt;
	logic signed [14:0] aln;
	logic signed [14:0] best;
	logic signed [5:0]  seed_gap;
	logic [6:0]   score;
	result_t      res_nx;

	assign rec_pop  = (state_q == ST_IDLE) && !rec_empty;
	assign out_free = !out_valid_q || pop;
	assign empty    = !out_valid_q;
	assign result   = out_q;

	// Restoring division step: one quotient bit per cycle, highest first.
	assign div_shift = {6'd0, div_q} << step_q;
	assign sub_ok    = (rem_q >= div_shift);

	// Final scoring from the quotient and the latched read record.
	always_comb begin
		avg_adj  = (quo_q[5:0] > AVG_OFFSET && !quo_q[6]) ? (quo_q[5:0] - AVG_OFFSET) :
			(quo_q[6] ? 6'd63 : 6'd0);
		budget   = $signed({5'd0, allowed_mismatches}) + 7'sd1 - $signed({2'd0, rec_q.best_seed});
		bud      = budget[2:0];
		case (bud)
			3'd0:    pen = missing_hit_penalties[7:0];
			3'd1:    pen = missing_hit_penalties[15:8];
			3'd2:    pen = missing_hit_penalties[23:16];
			3'd3:    pen = missing_hit_penalties[31:24];
			default: pen = missing_hit_penalties[39:32];
		endcase
		if (budget >= 7'sd0) begin
			alt = 10'(miss_base(allowed_mismatches)) + 10'(avg_adj * bud) + 10'(pen);
		end else begin
			alt = 10'd0;
		end
		seed_gap = $signed({1'b0, rec_q.second_seed}) - $signed({1'b0, rec_q.best_seed});
		if (!rec_q.has_second) begin
			aln = 15'sd99;
		end else begin
			aln = $signed({2'd0, rec_q.second_sum}) - $signed({2'd0, rec_q.best_sum})
				- $signed({7'd0, rec_q.penalty});
			if (seed_gap <= 6'sd1 && aln > $signed({9'd0, quality_cap})) begin
				aln = $signed({9'd0, quality_cap});
			end
		end
		best = ($signed({5'd0, alt}) < aln) ? $signed({5'd0, alt}) : aln;
		if (best < 15'sd0) begin
			score = 7'd0;
		end else if (best > $signed({8'd0, MAX_MAP_QUAL})) begin
			score = MAX_MAP_QUAL;
		end else begin
			score = best[6:0];
		end
		res_nx.no_match = !rec_q.has_match;
		if (rec_q.has_match) begin
			res_nx.map_score         = score;
			res_nx.mismatch_qual_sum = (rec_q.best_sum > SUM_W'(SUM_SAT)) ? SUM_SAT :
				rec_q.best_sum[7:0];
			res_nx.mismatch_count    = (rec_q.mismatch_tally > TALLY_W'(COUNT_SAT)) ? COUNT_SAT :
				rec_q.mismatch_tally[3:0];
		end else begin
			res_nx.map_score         = 7'd0;
			res_nx.mismatch_qual_sum = 8'd0;
			res_nx.mismatch_count    = 4'd0;
		end
	end

	// Working registers of the divider and the held read record.
	always_ff @(posedge clk) begin
		if (rec_pop) begin
			rec_q  <= rec;
			rem_q  <= {rec.total_sum, 1'b0} + 15'(rec.base_tally);
			div_q  <= {rec.base_tally, 1'b0};
			quo_q  <= 7'd0;
			step_q <= 3'd6;
		end else if (state_q == ST_DIV) begin
			if (sub_ok) begin
				rem_q <= rem_q - div_shift;
			end
			quo_q[step_q] <= sub_ok;
			step_q        <= step_q - 1'b1;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (rec_pop) begin
						state_q <= (rec.has_match && rec.base_tally != '0) ? ST_DIV : ST_SCORE;
					end
				end
				ST_DIV: begin
					if (step_q == 3'd0) begin
						state_q <= ST_SCORE;
					end
				end
				ST_SCORE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_SCORE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SCORE && out_free) begin
			out_q <= res_nx;
		end
	end

endmodule

>>> sv/read_mapping_quality.sv
// Read mapping quality block: base items stream in at one per cycle while full is low;
// each finished read passes the queue, the load, the divider steps and the score step,
// skipping the divider without a match or bases; the score step waits for a free output
// register. A two-entry queue lets the next read stream in meanwhile, and full rises
// only when two finished reads wait. Reset clears header latches, sums, queue and result;
// config is set to defaults. Depends on rmq_pkg, rmq_front, rmq_queue and rmq_back.
module read_mapping_quality import rmq_pkg::*; #(
	parameter int unsigned MAX_BASES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  item_t       item,
	output logic        empty,
	input  logic        pop,
	output result_t     result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [39:0] cfg_data
);

	logic [5:0]  quality_cap_q;
	logic [1:0]  allowed_mism_q;
	logic [39:0] miss_pen_q;

	logic        accept;
	logic        rec_push;
	rmq_rec_t    rec_in;
	rmq_rec_t    rec_out;
	logic        q_full;
	logic        q_empty;
	logic        rec_pop;

	assign cfg_ready = 1'b1;
	assign full      = q_full;
	assign accept    = push && !q_full;

	// Configuration registers; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quality_cap_q  <= 6'd63;
			allowed_mism_q <= 2'd2;
			miss_pen_q     <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_QUALITY_CAP:  quality_cap_q  <= cfg_data[5:0];
				CFG_ALLOWED_MISM: allowed_mism_q <= cfg_data[1:0];
				CFG_MISS_PENALTY: miss_pen_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	rmq_front #(
		.MAX_BASES (MAX_BASES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.item        (item),
		.quality_cap (quality_cap_q),
		.rec_push    (rec_push),
		.rec         (rec_in)
	);

	rmq_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rec_push),
		.wdata  (rec_in),
		.pop    (rec_pop),
		.rdata  (rec_out),
		.full   (q_full),
		.empty  (q_empty)
	);

	rmq_back u_back (
		.clk                   (clk),
		.arst_n                (arst_n),
		.rec                   (rec_out),
		.rec_empty             (q_empty),
		.rec_pop               (rec_pop),
		.quality_cap           (quality_cap_q),
		.allowed_mismatches    (allowed_mism_q),
		.missing_hit_penalties (miss_pen_q),
		.pop                   (pop),
		.empty                 (empty),
		.result                (result)
	);

	// A read without a hit carries no score or sums.
	a_no_match_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.no_match) |->
		(result.map_score == 7'd0 && result.mismatch_qual_sum == 8'd0 &&
		result.mismatch_count == 4'd0))
		else $error("no-match result carries nonzero fields");

	// The score is clamped to its range.
	a_score_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.map_score <= MAX_MAP_QUAL))
		else $error("mapping quality out of range");

	// Below count saturation, the mismatch sum is bounded by the quality ceiling.
	a_sum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.mismatch_count < COUNT_SAT) |->
		({2'd0, result.mismatch_qual_sum} <= 10'd63 * {6'd0, result.mismatch_count}))
		else $error("mismatch sum exceeds what the count allows");

	// A finished read is never pushed into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		rec_push |-> !q_full)
		else $error("read record pushed into full queue");

endmodule
